/* src/btt_pkg.sv */
// Shared types and constants for the bucketed transposition table.
// Used by every module of the block; depends on nothing.
package btt_pkg;

  localparam int INDEX_BITS = 12;
  localparam int WAYS       = 4;
  localparam int BUCKETS    = 1 << INDEX_BITS;
  localparam int WAY_IW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_LSB    = 48;
  localparam int TAG_W      = 16;

  localparam logic [14:0] MATE_THR_RST = 15'd31000;

  // configuration port
  localparam int APB_AW = 3;
  localparam logic [APB_AW-1:2] REG_MATE_THR = '0;

  localparam logic       OP_STORE     = 1'b0;
  localparam logic       OP_PROBE     = 1'b1;
  localparam logic [1:0] BOUND_EXACT  = 2'd2;

  localparam logic [1:0] STAT_MISS     = 2'd0;
  localparam logic [1:0] STAT_DROPPED  = 2'd0;
  localparam logic [1:0] STAT_HIT      = 2'd1;
  localparam logic [1:0] STAT_WRITTEN  = 2'd1;
  localparam logic [1:0] STAT_REPLACED = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [63:0]        position_key;
    logic [15:0]        best_move;
    logic signed [15:0] search_score;
    logic signed [15:0] static_score;
    logic [1:0]         bound_kind;
    logic signed [7:0]  search_depth;
    logic [6:0]         ply_from_root;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        found_move;
    logic signed [15:0] found_score;
    logic signed [15:0] found_static;
    logic [1:0]         found_bound;
    logic signed [7:0]  found_depth;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [1:0]         bound;
    logic signed [7:0]  depth;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic signed [15:0] static_score;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] addr;
  } mem_req_t;

  typedef struct packed {
    logic empty;
    logic tag_eq;
    logic ovr_ok;
    logic shallower;
  } way_eval_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

/* src/btt_mem.sv */
// Bucket memory: one row of all ways per bucket, registered read port.
// Depends on btt_pkg.
module btt_mem
  import btt_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  input  row_t     wr_row_i,
  output row_t     rd_row_o
);

  logic [ROW_W-1:0] mem_q [BUCKETS];
  logic [ROW_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= wr_row_i;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.addr];
    end
  end

  assign rd_row_o = row_t'(rd_q);

endmodule

/* src/btt_way_unit.sv */
// Shared compare unit: judges one way of the bucket against the request.
// Depends on btt_pkg.
module btt_way_unit
  import btt_pkg::*;
(
  input  way_t              way_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic [1:0]        bound_i,
  input  logic signed [7:0] depth_i,
  input  logic signed [8:0] min_i,
  output way_eval_t         eval_o
);

  logic signed [8:0] way_depth;

  assign way_depth        = {way_i.depth[7], way_i.depth};
  assign eval_o.empty     = !way_i.valid;
  assign eval_o.tag_eq    = (way_i.tag == tag_i);
  assign eval_o.ovr_ok    = (depth_i >= way_i.depth) || (bound_i == BOUND_EXACT);
  assign eval_o.shallower = (way_depth < min_i);

endmodule

/* src/btt_ctrl.sv */
// Sequencer: clears the table, reads a bucket, walks its ways through the
// shared compare unit, writes back a kept store and builds the result. Depends on btt_pkg.
module btt_ctrl
  import btt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [14:0] thr_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  output mem_req_t    mem_req_o,
  output row_t        mem_wr_row_o,
  input  row_t        mem_rd_row_i
);

  localparam logic [WAY_IW-1:0]     WAY_LAST = WAY_IW'(WAYS - 1);
  localparam logic [INDEX_BITS-1:0] CLR_LAST = '1;
  localparam logic signed [8:0]     MIN_INIT = 9'sd128;

  state_e              state_q, state_d;
  logic [INDEX_BITS-1:0] clr_q, clr_d;
  logic [WAY_IW-1:0]   way_q, way_d;
  logic [WAY_IW-1:0]   victim_q, victim_d;
  logic signed [8:0]   min_q, min_d;
  logic [1:0]          stat_q, stat_d;
  logic                wr_q, wr_d;
  in_word_t            req_q, req_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;

  way_t                cur_way;
  way_t                sel_way;
  way_t                new_way;
  way_eval_t           eval;
  logic [TAG_W-1:0]    req_tag;
  logic signed [16:0]  score_x, thr_x, ply_x, score_adj;
  out_word_t           result;
  row_t                new_row;

  assign req_tag = req_q.position_key[TAG_LSB +: TAG_W];
  assign cur_way = mem_rd_row_i[way_q];
  assign sel_way = mem_rd_row_i[victim_q];

  btt_way_unit u_way_unit (
    .way_i   (cur_way),
    .tag_i   (req_tag),
    .bound_i (req_q.bound_kind),
    .depth_i (req_q.search_depth),
    .min_i   (min_q),
    .eval_o  (eval)
  );

  // mate scores move toward zero by the ply
  always_comb begin
    score_x = {sel_way.score[15], sel_way.score};
    thr_x   = {2'b00, thr_i};
    ply_x   = {10'd0, req_q.ply_from_root};
    if (score_x > thr_x) begin
      score_adj = score_x - ply_x;
    end else if (score_x < -thr_x) begin
      score_adj = score_x + ply_x;
    end else begin
      score_adj = score_x;
    end
  end

  always_comb begin
    result        = '0;
    result.status = stat_q;
    if (req_q.opcode == OP_PROBE && stat_q == STAT_HIT) begin
      result.found_move   = sel_way.move;
      result.found_score  = score_adj[15:0];
      result.found_static = sel_way.static_score;
      result.found_bound  = sel_way.bound;
      result.found_depth  = sel_way.depth;
    end
  end

  always_comb begin
    new_way.valid        = 1'b1;
    new_way.tag          = req_tag;
    new_way.bound        = req_q.bound_kind;
    new_way.depth        = req_q.search_depth;
    new_way.move         = req_q.best_move;
    new_way.score        = req_q.search_score;
    new_way.static_score = req_q.static_score;
    new_row              = mem_rd_row_i;
    new_row[victim_q]    = new_way;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      way_q       <= '0;
      victim_q    <= '0;
      min_q       <= MIN_INIT;
      stat_q      <= STAT_MISS;
      wr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      way_q       <= way_d;
      victim_q    <= victim_d;
      min_q       <= min_d;
      stat_q      <= stat_d;
      wr_q        <= wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    way_d        = way_q;
    victim_d     = victim_q;
    min_d        = min_q;
    stat_d       = stat_q;
    wr_d         = wr_q;
    req_d        = req_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    in_stall_o   = 1'b1;
    mem_req_o    = '0;
    mem_wr_row_o = new_row;

    case (state_q)
      ST_CLEAR: begin
        mem_req_o.wr_en = 1'b1;
        mem_req_o.addr  = clr_q;
        mem_wr_row_o    = '0;
        clr_d           = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d           = in_word_i;
          mem_req_o.rd_en = 1'b1;
          mem_req_o.addr  = in_word_i.position_key[INDEX_BITS-1:0];
          way_d           = '0;
          victim_d        = '0;
          min_d           = MIN_INIT;
          state_d         = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (req_q.opcode == OP_STORE) begin
          if (eval.empty || (eval.tag_eq && eval.ovr_ok)) begin
            victim_d = way_q;
            stat_d   = STAT_WRITTEN;
            wr_d     = 1'b1;
            state_d  = ST_FINISH;
          end else if (eval.tag_eq) begin
            // same position already held deeper: drop the store
            stat_d  = STAT_DROPPED;
            wr_d    = 1'b0;
            state_d = ST_FINISH;
          end else begin
            if (eval.shallower) begin
              min_d    = {cur_way.depth[7], cur_way.depth};
              victim_d = way_q;
            end
            if (way_q == WAY_LAST) begin
              stat_d  = STAT_REPLACED;
              wr_d    = 1'b1;
              state_d = ST_FINISH;
            end else begin
              way_d = way_q + 1'b1;
            end
          end
        end else begin
          wr_d = 1'b0;
          if (!eval.empty && eval.tag_eq) begin
            victim_d = way_q;
            stat_d   = STAT_HIT;
            state_d  = ST_FINISH;
          end else if (way_q == WAY_LAST) begin
            stat_d  = STAT_MISS;
            state_d = ST_FINISH;
          end else begin
            way_d = way_q + 1'b1;
          end
        end
      end

      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d           = result;
          mem_req_o.wr_en = wr_q;
          mem_req_o.addr  = req_q.position_key[INDEX_BITS-1:0];
          state_d         = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* src/bucketed_transposition_table.sv */
// Set-associative transposition table with depth-preferred replacement.
// After reset the block sweeps the table clear, one bucket per cycle, and
// takes no word meanwhile; configuration writes are taken at any time.
// Each store or probe then reads the bucket from block memory, walks the
// ways one per cycle through the single compare unit until the way is
// decided, and then, once the result register is free, writes the bucket
// back (for a store that is not dropped) and loads the result register. A
// new word is taken as soon as the result is loaded, even while it waits
// to be taken. Depends on btt_pkg, btt_ctrl, btt_mem.
module bucketed_transposition_table
  import btt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o
);

  logic [14:0] thr_q;
  mem_req_t    mem_req;
  row_t        mem_wr_row;
  row_t        mem_rd_row;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= MATE_THR_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[APB_AW-1:2] == REG_MATE_THR) begin
      thr_q <= pwdata[14:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_MATE_THR) begin
      prdata = {17'd0, thr_q};
    end
  end

  btt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thr_i        (thr_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o),
    .mem_req_o    (mem_req),
    .mem_wr_row_o (mem_wr_row),
    .mem_rd_row_i (mem_rd_row)
  );

  btt_mem u_mem (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .wr_row_i (mem_wr_row),
    .rd_row_o (mem_rd_row)
  );

endmodule

/* src/btt_chk.sv */
// Port-level checks for the transposition table, bound to the top level.
// Depends on btt_pkg.
module btt_chk
  import btt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in work");

  // no result appears in the cycle that reads the bucket
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result ahead of bucket read");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.status != 2'd3)
    else $error("undefined status code");

  // misses and dropped stores carry no entry
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == STAT_MISS |->
      out_word_o.found_move == '0 && out_word_o.found_score == '0 &&
      out_word_o.found_static == '0 && out_word_o.found_bound == '0 &&
      out_word_o.found_depth == '0)
    else $error("entry fields set without a hit");

endmodule

bind bucketed_transposition_table btt_chk u_chk (.*);
